>>> src/lrc_pkg.sv
// ============================================================================
// lrc_pkg
// Shared types and constants for the LRC lyric line parser.
// ============================================================================
package lrc_pkg;

    localparam logic [7:0] MAX_LINE_BYTES = 8'd255;
    localparam int         QUEUE_DEPTH    = 4;
    localparam int         QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LANGLE = 8'h3C;
    localparam logic [7:0] CH_RANGLE = 8'h3E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic KIND_TEXT  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    typedef enum logic [2:0] {
        MODE_START,
        MODE_MIN,
        MODE_SEC,
        MODE_FRAC,
        MODE_TEXT,
        MODE_ANGLE
    } lrc_mode_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text_byte;
        logic        is_translation;
        logic [15:0] tag_minutes;
        logic [15:0] tag_seconds;
        logic [7:0]  tag_hundredths;
        logic [7:0]  line_length;
        logic        last_of_run;
    } lrc_result_t;

endpackage

>>> src/lrc_text_if.sv
// ============================================================================
// lrc_text_if
// Input byte channel: valid/ready handshake with one text byte per transaction.
// ============================================================================
interface lrc_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

>>> src/lrc_result_if.sv
// ============================================================================
// lrc_result_if
// Result channel: valid/ready handshake with one kept byte or close record
// per transaction.
// ============================================================================
interface lrc_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  text_byte;
    logic        is_translation;
    logic [15:0] tag_minutes;
    logic [15:0] tag_seconds;
    logic [7:0]  tag_hundredths;
    logic [7:0]  line_length;
    logic        last_of_run;

    modport source (output valid, output kind, output text_byte, output is_translation,
                    output tag_minutes, output tag_seconds, output tag_hundredths,
                    output line_length, output last_of_run, input ready);
    modport sink   (input valid, input kind, input text_byte, input is_translation,
                    input tag_minutes, input tag_seconds, input tag_hundredths,
                    input line_length, input last_of_run, output ready);
endinterface

>>> src/lrc_lyric_line_parser_unit.sv
// ============================================================================
// lrc_lyric_line_parser_unit
// Byte-wide LRC lyric parser: line tags, kept text bytes and close records.
// ============================================================================
// Channels: text (sink) takes one lyric byte per transaction, with
// end_of_text on the final byte. result (source) gives one kept text byte
// or one line close record per transaction; last_of_run marks the final
// result caused by a byte. A byte yields zero, one or two results.
// Throughput: one byte per cycle while results drain; a byte that yields
// two results takes two output transactions. The parse state is
// updated in the cycle a byte is taken, and its results enter a four-entry
// output queue; text.ready is high while the queue holds two or fewer
// entries, so the rate is set by the single result port draining that queue.
// A taken byte's results are registered behind any results already queued.
// Reset: parse state returns to line start with no tag, no prior original
// line and an empty queue. end_of_text also returns the parse state to
// its reset value after closing any open line.
// Stall: when result.ready is low the queue fills and text.ready drops;
// queued results hold steady until taken.
// ============================================================================
module lrc_lyric_line_parser_unit
    import lrc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    lrc_text_if.sink            text,
    lrc_result_if.source        result
);

    lrc_mode_t   mode_reg,  mode_next;
    logic [15:0] min_reg,   min_next;
    logic [15:0] sec_reg,   sec_next;
    logic [7:0]  hund_reg,  hund_next;
    logic [39:0] ptag_reg,  ptag_next;
    logic [7:0]  kept_reg,  kept_next;
    logic        open_reg,  open_next;
    logic        trans_reg, trans_next;
    logic        prior_reg, prior_next;

    lrc_result_t q_reg [QUEUE_DEPTH];
    lrc_result_t q_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    logic        accept;
    logic        pop;
    logic        emit_byte;
    logic        emit_close;
    lrc_result_t byte_res;
    lrc_result_t close_res;

    assign accept = text.valid && text.ready;
    assign pop    = result.valid && result.ready;

    always_comb
    begin
        logic [7:0]  b;
        logic        digit;
        logic [3:0]  d;
        logic        done;
        logic        do_text;
        logic        close_text;
        logic        close_now;
        lrc_mode_t   m;
        logic [15:0] mi;
        logic [15:0] se;
        logic [7:0]  hu;
        logic [7:0]  cnt;
        logic        fo;
        logic        ft;
        logic        fp;
        logic [39:0] pt;

        b          = text.data_byte;
        digit      = (b >= CH_ZERO) && (b <= CH_NINE);
        d          = b[3:0];
        done       = 1'b0;
        do_text    = 1'b0;
        close_text = 1'b0;
        close_now  = 1'b0;
        m          = mode_reg;
        mi         = min_reg;
        se         = sec_reg;
        hu         = hund_reg;
        cnt        = kept_reg;
        fo         = open_reg;
        ft         = trans_reg;
        fp         = prior_reg;
        pt         = ptag_reg;
        emit_byte  = 1'b0;
        emit_close = 1'b0;
        byte_res   = '0;
        close_res  = '0;

        unique case (m)
            MODE_START:
            begin
                if (b == CH_CR || b == CH_LF)
                begin
                    fp = fp;
                end
                else if (b == CH_SPACE)
                begin
                    fp = 1'b0;
                end
                else
                begin
                    fo = 1'b1;
                    if (b == CH_LBRACK)
                    begin
                        m = MODE_MIN;
                    end
                    else
                    begin
                        fp      = 1'b0;
                        m       = MODE_TEXT;
                        do_text = 1'b1;
                    end
                end
            end
            MODE_TEXT, MODE_ANGLE:
            begin
                do_text = 1'b1;
            end
            MODE_MIN, MODE_SEC, MODE_FRAC:
            begin
                if (m == MODE_MIN)
                begin
                    if (digit)
                    begin
                        mi   = {mi[12:0], 3'b000} + {mi[14:0], 1'b0} + {12'd0, d};
                        done = 1'b1;
                    end
                    else if (b == CH_COLON)
                    begin
                        m    = MODE_SEC;
                        done = 1'b1;
                    end
                    else
                    begin
                        m = MODE_SEC;
                    end
                end
                if (!done && m == MODE_SEC)
                begin
                    if (digit)
                    begin
                        se   = {se[12:0], 3'b000} + {se[14:0], 1'b0} + {12'd0, d};
                        done = 1'b1;
                    end
                    else if (b == CH_DOT)
                    begin
                        m    = MODE_FRAC;
                        done = 1'b1;
                    end
                    else
                    begin
                        m = MODE_FRAC;
                    end
                end
                if (!done && m == MODE_FRAC)
                begin
                    if (digit)
                    begin
                        hu = {hu[4:0], 3'b000} + {hu[6:0], 1'b0} + {4'd0, d};
                    end
                    else
                    begin
                        if (fp && {mi, se, hu} == pt)
                        begin
                            ft = 1'b1;
                        end
                        m = MODE_TEXT;
                        if (b != CH_RBRACK)
                        begin
                            do_text = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                m = MODE_START;
            end
        endcase

        if (do_text)
        begin
            if (m == MODE_ANGLE)
            begin
                if (b == CH_RANGLE)
                begin
                    m = MODE_TEXT;
                end
            end
            else if (b == CH_CR || b == CH_LF)
            begin
                close_text = 1'b1;
            end
            else if (b == CH_LANGLE && !ft)
            begin
                m = MODE_ANGLE;
            end
            else
            begin
                emit_byte                = 1'b1;
                byte_res.kind            = KIND_TEXT;
                byte_res.text_byte       = b;
                byte_res.is_translation  = ft;
                byte_res.tag_minutes     = mi;
                byte_res.tag_seconds     = se;
                byte_res.tag_hundredths  = hu;
                cnt                      = cnt + 8'd1;
                if (cnt >= MAX_LINE_BYTES)
                begin
                    close_text = 1'b1;
                end
            end
        end

        // end of text closes an open line, finishing a pending tag first
        if (close_text)
        begin
            close_now = 1'b1;
        end
        else if (text.end_of_text && fo)
        begin
            if ((m == MODE_MIN || m == MODE_SEC || m == MODE_FRAC)
                && fp && {mi, se, hu} == pt)
            begin
                ft = 1'b1;
            end
            close_now = 1'b1;
        end

        if (close_now)
        begin
            emit_close               = 1'b1;
            close_res.kind           = KIND_CLOSE;
            close_res.is_translation = ft;
            close_res.tag_minutes    = mi;
            close_res.tag_seconds    = se;
            close_res.tag_hundredths = hu;
            close_res.line_length    = cnt;
            close_res.last_of_run    = 1'b1;
            if (ft)
            begin
                fp = 1'b0;
            end
            else
            begin
                fp = 1'b1;
                pt = {mi, se, hu};
            end
            fo  = 1'b0;
            ft  = 1'b0;
            cnt = 8'd0;
            mi  = 16'd0;
            se  = 16'd0;
            hu  = 8'd0;
            m   = MODE_START;
        end

        byte_res.last_of_run = !close_now;

        if (text.end_of_text)
        begin
            m   = MODE_START;
            mi  = 16'd0;
            se  = 16'd0;
            hu  = 8'd0;
            pt  = 40'd0;
            cnt = 8'd0;
            fo  = 1'b0;
            ft  = 1'b0;
            fp  = 1'b0;
        end

        if (accept)
        begin
            mode_next  = m;
            min_next   = mi;
            sec_next   = se;
            hund_next  = hu;
            ptag_next  = pt;
            kept_next  = cnt;
            open_next  = fo;
            trans_next = ft;
            prior_next = fp;
        end
        else
        begin
            mode_next  = mode_reg;
            min_next   = min_reg;
            sec_next   = sec_reg;
            hund_next  = hund_reg;
            ptag_next  = ptag_reg;
            kept_next  = kept_reg;
            open_next  = open_reg;
            trans_next = trans_reg;
            prior_next = prior_reg;
        end
    end

    // Output queue: entry 0 drives the port, pops shift toward it.
    always_comb
    begin
        logic [QCNT_W-1:0] base;
        logic              push_a;
        logic              push_b;
        lrc_result_t       first_res;

        base      = cnt_reg - {{(QCNT_W-1){1'b0}}, pop};
        push_a    = accept && (emit_byte || emit_close);
        push_b    = accept && emit_byte && emit_close;
        first_res = emit_byte ? byte_res : close_res;

        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && i < QUEUE_DEPTH - 1)
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if (push_a && base == QCNT_W'(i))
            begin
                q_next[i] = first_res;
            end
            if (push_b && base + QCNT_W'(1) == QCNT_W'(i))
            begin
                q_next[i] = close_res;
            end
        end

        cnt_next = base + {{(QCNT_W-1){1'b0}}, push_a} + {{(QCNT_W-1){1'b0}}, push_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_START;
            min_reg   <= '0;
            sec_reg   <= '0;
            hund_reg  <= '0;
            ptag_reg  <= '0;
            kept_reg  <= '0;
            open_reg  <= 1'b0;
            trans_reg <= 1'b0;
            prior_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            hund_reg  <= hund_next;
            ptag_reg  <= ptag_next;
            kept_reg  <= kept_next;
            open_reg  <= open_next;
            trans_reg <= trans_next;
            prior_reg <= prior_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign text.ready            = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign result.valid          = (cnt_reg != '0);
    assign result.kind           = q_reg[0].kind;
    assign result.text_byte      = q_reg[0].text_byte;
    assign result.is_translation = q_reg[0].is_translation;
    assign result.tag_minutes    = q_reg[0].tag_minutes;
    assign result.tag_seconds    = q_reg[0].tag_seconds;
    assign result.tag_hundredths = q_reg[0].tag_hundredths;
    assign result.line_length    = q_reg[0].line_length;
    assign result.last_of_run    = q_reg[0].last_of_run;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text.end_of_text |=> mode_reg == MODE_START && !open_reg && !prior_reg)
        else $error("end of text did not restore parse state");

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg < MAX_LINE_BYTES)
        else $error("kept count reached line limit without close");

    a_queue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept && !pop |=> $stable(cnt_reg))
        else $error("queue count moved without a transaction");

endmodule
